>>> design/qs_pkg.sv
// Shared constants, datapath operation codes and status bundle of the sort engine.
package qs_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int WIDTH_DEF = 32;
  localparam int VAL_W     = 32;

  typedef enum logic [4:0] {
    OP_NONE   = 5'd0,
    OP_LOAD   = 5'd1,
    OP_START  = 5'd2,
    OP_POP_RD = 5'd3,
    OP_POP_LD = 5'd4,
    OP_PIV_RD = 5'd5,
    OP_PIV_LD = 5'd6,
    OP_L_ADV  = 5'd7,
    OP_L_STOP = 5'd8,
    OP_R_ADV  = 5'd9,
    OP_R_SWAP = 5'd10,
    OP_R_FIN  = 5'd11,
    OP_SWAP2  = 5'd12,
    OP_FIN2   = 5'd13,
    OP_PUSH_R = 5'd14,
    OP_PUSH_L = 5'd15,
    OP_EMIT   = 5'd16
  } dp_op_t;

  typedef struct packed {
    logic fill_ge2;
    logic sp_zero;
    logic range_ok;
    logic l_lt_hi;
    logic l_lt_r;
    logic r_gt_lo;
    logic goes_before;
    logic need_push_r;
    logic need_push_l;
    logic emit_last;
    logic out_free;
  } qs_status_t;

endpackage

>>> design/quicksort_engine.sv
// Loading takes one beat per cycle; the closing beat stalls input until the final result beat
// sits in the output register. Sorting is data dependent: each scan step tests one element
// per cycle through the single read port of the store, an exchange adds the S_SWAP2 step, and
// each range adds the steps of pop, pivot fetch, pivot placement and push; worst case grows
// with the square of the count. Emission reads an element, then registers it once not stalled.
// Synchronous active-low reset clears control state; store and stack need no clearing.
module quicksort_engine
  import qs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    in_last_item,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [VAL_W-1:0] out_sorted_value,
  output logic                    out_final_item,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic                    cfg_descending
);

  dp_op_t     op;
  qs_status_t sts;

  assign cfg_ready = 1'b1;

  qs_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_last_item (in_last_item),
    .in_stall     (in_stall),
    .sts          (sts),
    .op           (op)
  );

  qs_datapath #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .in_value         (in_value),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_descending   (cfg_descending),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_final_item   (out_final_item),
    .sts              (sts)
  );

endmodule

>>> design/qs_ctrl.sv
// Controller state machine that sequences loading, partitioning and emission.
module qs_ctrl
  import qs_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_last_item,
  output logic       in_stall,
  input  qs_status_t sts,
  output dp_op_t     op
);

  typedef enum logic [13:0] {
    S_LOAD      = 14'b00000000000001,
    S_START     = 14'b00000000000010,
    S_POP       = 14'b00000000000100,
    S_POP_CHK   = 14'b00000000001000,
    S_PIV_RD    = 14'b00000000010000,
    S_PIV_LD    = 14'b00000000100000,
    S_LCHK      = 14'b00000001000000,
    S_RCHK      = 14'b00000010000000,
    S_SWAP2     = 14'b00000100000000,
    S_FIN2      = 14'b00001000000000,
    S_PUSH_R    = 14'b00010000000000,
    S_PUSH_L    = 14'b00100000000000,
    S_EMIT_RD   = 14'b01000000000000,
    S_EMIT_WAIT = 14'b10000000000000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    in_stall  = (state_r != S_LOAD);
    unique case (state_r)
      S_LOAD: begin
        if (in_valid) begin
          op = OP_LOAD;
          if (in_last_item) state_nxt = S_START;
        end
      end
      S_START: begin
        if (sts.fill_ge2) begin
          op        = OP_START;
          state_nxt = S_PIV_RD;
        end else begin
          state_nxt = S_EMIT_RD;
        end
      end
      S_POP: begin
        if (sts.sp_zero) begin
          state_nxt = S_EMIT_RD;
        end else begin
          op        = OP_POP_RD;
          state_nxt = S_POP_CHK;
        end
      end
      S_POP_CHK: begin
        op        = OP_POP_LD;
        state_nxt = sts.range_ok ? S_PIV_RD : S_POP;
      end
      S_PIV_RD: begin
        op        = OP_PIV_RD;
        state_nxt = S_PIV_LD;
      end
      S_PIV_LD: begin
        op        = OP_PIV_LD;
        state_nxt = S_LCHK;
      end
      S_LCHK: begin
        if (sts.l_lt_hi && sts.goes_before) begin
          op = OP_L_ADV;
        end else begin
          op        = OP_L_STOP;
          state_nxt = S_RCHK;
        end
      end
      S_RCHK: begin
        if (sts.r_gt_lo && !sts.goes_before) begin
          op = OP_R_ADV;
        end else if (sts.l_lt_r) begin
          op        = OP_R_SWAP;
          state_nxt = S_SWAP2;
        end else begin
          op        = OP_R_FIN;
          state_nxt = S_FIN2;
        end
      end
      S_SWAP2: begin
        // The second half of the exchange also fetches the left element again.
        op        = OP_SWAP2;
        state_nxt = S_LCHK;
      end
      S_FIN2: begin
        op        = OP_FIN2;
        state_nxt = S_PUSH_R;
      end
      S_PUSH_R: begin
        if (sts.need_push_r) op = OP_PUSH_R;
        state_nxt = S_PUSH_L;
      end
      S_PUSH_L: begin
        if (sts.need_push_l) op = OP_PUSH_L;
        state_nxt = S_POP;
      end
      S_EMIT_RD: begin
        state_nxt = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (sts.out_free) begin
          op        = OP_EMIT;
          state_nxt = sts.emit_last ? S_LOAD : S_EMIT_RD;
        end
      end
      default: begin
        state_nxt = S_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> design/qs_datapath.sv
// Element store, range stack, partition indices and output register of the sort engine.
module qs_datapath
  import qs_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF,
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  dp_op_t                  op,
  input  logic signed [VAL_W-1:0] in_value,
  input  logic                    cfg_we,
  input  logic                    cfg_descending,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic signed [VAL_W-1:0] out_sorted_value,
  output logic                    out_final_item,
  output qs_status_t              sts
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0]   store_mem [DEPTH];
  logic [2*IDX_W-1:0] stack_mem [DEPTH];

  logic [CNT_W-1:0] fill_r, fill_nxt;
  logic [CNT_W-1:0] sp_r, sp_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic             desc_r, desc_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;
  logic             out_final_r, out_final_nxt;
  logic [IDX_W-1:0] l_r, l_nxt;
  logic [IDX_W-1:0] r_r, r_nxt;
  logic [IDX_W-1:0] lo_r, lo_nxt;
  logic [IDX_W-1:0] hi_r, hi_nxt;
  logic [WIDTH-1:0] p_r, p_nxt;
  logic [WIDTH-1:0] lval_r, lval_nxt;

  logic [WIDTH-1:0]   rd_r;
  logic [2*IDX_W-1:0] stk_rd_r;

  logic [IDX_W-1:0]       rd_addr;
  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [WIDTH-1:0]       wr_data;
  logic                   stk_we;
  logic [2*IDX_W-1:0]     stk_wdata;
  logic [CNT_W-1:0]       sp_dec;
  logic [CNT_W-1:0]       fill_dec;
  logic [WIDTH+VAL_W-1:0] in_ext;
  logic [WIDTH+VAL_W-1:0] out_ext;
  logic [IDX_W-1:0]       stk_lo;
  logic [IDX_W-1:0]       stk_hi;
  logic                   store_room;
  logic                   stack_room;

  assign sp_dec     = sp_r - 1'b1;
  assign fill_dec   = fill_r - 1'b1;
  assign in_ext     = {{WIDTH{1'b0}}, in_value};
  assign out_ext    = {{VAL_W{1'b0}}, rd_r};
  assign stk_lo     = stk_rd_r[IDX_W-1:0];
  assign stk_hi     = stk_rd_r[2*IDX_W-1:IDX_W];
  assign store_room = (fill_r < CNT_W'(DEPTH));
  assign stack_room = (sp_r < CNT_W'(DEPTH));

  // Order test against the pivot: true when the fetched element may stay on the left side.
  always_comb begin
    sts.goes_before = desc_r ? ($signed(rd_r) >= $signed(p_r))
                             : ($signed(rd_r) <= $signed(p_r));
    sts.fill_ge2    = (fill_r >= CNT_W'(2));
    sts.sp_zero     = (sp_r == '0);
    sts.range_ok    = (stk_lo < stk_hi) && (CNT_W'(stk_hi) < fill_r);
    sts.l_lt_hi     = (l_r < hi_r);
    sts.l_lt_r      = (l_r < r_r);
    sts.r_gt_lo     = (r_r > lo_r);
    sts.need_push_r = ({1'b0, r_r} + 1'b1) < {1'b0, hi_r};
    sts.need_push_l = {1'b0, r_r} > ({1'b0, lo_r} + 1'b1);
    sts.emit_last   = ((i_r + 1'b1) == fill_r);
    sts.out_free    = !out_valid_r || !out_stall;
  end

  always_comb begin
    case (op)
      OP_PIV_RD: rd_addr = lo_r;
      OP_PIV_LD: rd_addr = l_r;
      OP_L_ADV:  rd_addr = l_r + 1'b1;
      OP_L_STOP: rd_addr = r_r;
      OP_R_ADV:  rd_addr = r_r - 1'b1;
      OP_SWAP2:  rd_addr = l_r;
      default:   rd_addr = i_r[IDX_W-1:0];
    endcase
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = fill_r[IDX_W-1:0];
    wr_data = in_ext[WIDTH-1:0];
    case (op)
      OP_LOAD: begin
        wr_en = store_room;
      end
      OP_R_SWAP: begin
        wr_en   = 1'b1;
        wr_addr = l_r;
        wr_data = rd_r;
      end
      OP_R_FIN: begin
        wr_en   = 1'b1;
        wr_addr = lo_r;
        wr_data = rd_r;
      end
      OP_SWAP2: begin
        wr_en   = 1'b1;
        wr_addr = r_r;
        wr_data = lval_r;
      end
      OP_FIN2: begin
        wr_en   = 1'b1;
        wr_addr = r_r;
        wr_data = p_r;
      end
      default: begin
        wr_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    fill_nxt      = fill_r;
    sp_nxt        = sp_r;
    i_nxt         = i_r;
    desc_nxt      = cfg_we ? cfg_descending : desc_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_final_nxt = out_final_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    p_nxt         = p_r;
    lval_nxt      = lval_r;
    stk_we        = 1'b0;
    stk_wdata     = {hi_r, r_r + 1'b1};
    case (op)
      OP_LOAD: begin
        if (store_room) fill_nxt = fill_r + 1'b1;
      end
      OP_START: begin
        lo_nxt = '0;
        hi_nxt = fill_dec[IDX_W-1:0];
        sp_nxt = '0;
      end
      OP_POP_RD: begin
        sp_nxt = sp_dec;
      end
      OP_POP_LD: begin
        lo_nxt = stk_lo;
        hi_nxt = stk_hi;
      end
      OP_PIV_RD: begin
        l_nxt = lo_r;
        r_nxt = hi_r;
      end
      OP_PIV_LD: begin
        p_nxt = rd_r;
      end
      OP_L_ADV: begin
        l_nxt = l_r + 1'b1;
      end
      OP_L_STOP: begin
        lval_nxt = rd_r;
      end
      OP_R_ADV: begin
        r_nxt = r_r - 1'b1;
      end
      OP_PUSH_R: begin
        stk_we    = stack_room;
        stk_wdata = {hi_r, r_r + 1'b1};
        if (stack_room) sp_nxt = sp_r + 1'b1;
      end
      OP_PUSH_L: begin
        stk_we    = stack_room;
        stk_wdata = {r_r - 1'b1, lo_r};
        if (stack_room) sp_nxt = sp_r + 1'b1;
      end
      OP_EMIT: begin
        out_valid_nxt = 1'b1;
        out_value_nxt = out_ext[VAL_W-1:0];
        out_final_nxt = sts.emit_last;
        if (sts.emit_last) begin
          i_nxt    = '0;
          fill_nxt = '0;
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      default: begin
        fill_nxt = fill_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      sp_r        <= '0;
      i_r         <= '0;
      desc_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      fill_r      <= fill_nxt;
      sp_r        <= sp_nxt;
      i_r         <= i_nxt;
      desc_r      <= desc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r <= out_value_nxt;
    out_final_r <= out_final_nxt;
    l_r         <= l_nxt;
    r_r         <= r_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    p_r         <= p_nxt;
    lval_r      <= lval_nxt;
  end

  // The store has one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) store_mem[wr_addr] <= wr_data;
    rd_r <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stack_mem[sp_r[IDX_W-1:0]] <= stk_wdata;
    if (op == OP_POP_RD) stk_rd_r <= stack_mem[sp_dec[IDX_W-1:0]];
  end

  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_final_item   = out_final_r;

endmodule

>>> design/qs_checker.sv
// Port-level checks of the sort engine and their attachment to the top level.
module qs_checker
  import qs_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_stall,
  input logic             in_last_item,
  input logic             out_valid,
  input logic             out_stall,
  input logic [VAL_W-1:0] out_sorted_value,
  input logic             out_final_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_sorted_value) && $stable(out_final_item))
    else $error("stalled result beat changed");

  a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_last_item |=> in_stall)
    else $error("input not stalled after the closing beat");

  a_plain_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_last_item |=> !in_stall)
    else $error("input stalled during loading");

  a_reopen_final: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_stall) |-> out_valid && out_final_item)
    else $error("input reopened without the final result beat");

endmodule

bind quicksort_engine qs_checker u_qs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_last_item     (in_last_item),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_sorted_value (out_sorted_value),
  .out_final_item   (out_final_item)
);

>>> sim/quicksort_engine_tb.sv
// Self-checking testbench for the quicksort engine: random sets, both orders, random idling.
`timescale 1ns / 1ps

module quicksort_engine_tb;
  import qs_pkg::*;

  localparam int HELD_MAX     = DEPTH_DEF;
  localparam int RANDOM_ITEMS = 88;
  localparam int SETTLE_GAP   = 40;
  localparam int LIMIT_CYCLES = 600000;

  typedef enum int {SPREAD_WIDE, SPREAD_NARROW, SPREAD_EDGES, SPREAD_RUN} spread_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    last_item;
  } load_beat_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] value;
    logic                    final_item;
  } sorted_beat_t;

  typedef struct {
    int lo;
    int hi;
  } span_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [VAL_W-1:0] in_value = '0;
  logic in_last_item = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [VAL_W-1:0] out_sorted_value;
  logic out_final_item;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_descending = 1'b0;

  load_beat_t   load_queue[$];
  sorted_beat_t sorted_due[$];
  span_t        span_stack[$];

  logic signed [VAL_W-1:0] held_vals[HELD_MAX];
  int  held = 0;
  bit  order_desc = 1'b0;

  bit  in_took = 1'b0;
  bit  out_took = 1'b0;
  int  in_gap_left = 0;
  int  out_wait_left = 0;
  bit  in_calm = 1'b0;
  bit  out_calm = 1'b0;
  int  mismatch_count = 0;
  int  cycle_count = 0;

  quicksort_engine DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .in_last_item     (in_last_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_sorted_value (out_sorted_value),
    .out_final_item   (out_final_item),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_descending   (cfg_descending)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  // True when x may sit at or before the pivot in the current order.
  function automatic bit ranks_before(logic signed [VAL_W-1:0] x,
                                      logic signed [VAL_W-1:0] pivot);
    return order_desc ? (x >= pivot) : (x <= pivot);
  endfunction

  function automatic void swap_held(int i, int j);
    logic signed [VAL_W-1:0] t;
    t = held_vals[i];
    held_vals[i] = held_vals[j];
    held_vals[j] = t;
  endfunction

  // Hoare-style partition with the first element as pivot; returns its final slot.
  function automatic int split_span(int lo, int hi);
    logic signed [VAL_W-1:0] pivot;
    int l;
    int r;
    pivot = held_vals[lo];
    l = lo;
    r = hi;
    while (l < r) begin
      while (l < hi && ranks_before(held_vals[l], pivot)) l++;
      while (r > lo && !ranks_before(held_vals[r], pivot)) r--;
      if (l < r) swap_held(l, r);
    end
    swap_held(lo, r);
    return r;
  endfunction

  function automatic void push_span(int lo, int hi);
    span_t s;
    if (lo < hi && span_stack.size() < HELD_MAX) begin
      s.lo = lo;
      s.hi = hi;
      span_stack.push_back(s);
    end
  endfunction

  function automatic void order_held();
    span_t s;
    int m;
    span_stack.delete();
    if (held >= 2) begin
      push_span(0, held - 1);
      while (span_stack.size() != 0) begin
        s = span_stack.pop_back();
        if (s.hi < held && s.lo < s.hi) begin
          m = split_span(s.lo, s.hi);
          if (m + 1 < s.hi) push_span(m + 1, s.hi);
          if (m > s.lo + 1) push_span(s.lo, m - 1);
        end
      end
    end
  endfunction

  // Absorbs one accepted element; a last element releases the whole sorted set.
  function automatic void take_element(logic signed [VAL_W-1:0] v, logic last_item);
    sorted_beat_t b;
    if (held < HELD_MAX) begin
      held_vals[held] = v;
      held++;
    end
    if (last_item) begin
      order_held();
      for (int i = 0; i < held; i++) begin
        b.value = held_vals[i];
        b.final_item = (i == held - 1);
        sorted_due.push_back(b);
      end
      held = 0;
    end
  endfunction

  function automatic int draw_pause(bit calm);
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  // Input driver: holds a stalled beat, otherwise waits out its gap and presents the next one.
  always @(negedge clk) begin
    int gap;
    load_beat_t b;
    if (rst_n && !(in_valid && !in_took)) begin
      gap = in_took ? draw_pause(in_calm) : in_gap_left;
      if (gap > 0 || load_queue.size() == 0) begin
        in_valid <= 1'b0;
        in_gap_left <= (gap > 0) ? gap - 1 : 0;
      end else begin
        b = load_queue.pop_front();
        in_valid <= 1'b1;
        in_value <= b.value;
        in_last_item <= b.last_item;
        in_gap_left <= 0;
      end
    end
  end

  // Result receiver stall: after each accepted beat, stall for a freshly drawn number of cycles.
  always @(negedge clk) begin
    int w;
    if (rst_n) begin
      w = out_took ? draw_pause(out_calm) : out_wait_left;
      out_stall <= (w > 0);
      out_wait_left <= (w > 0) ? w - 1 : 0;
    end
  end

  always @(posedge clk) begin
    sorted_beat_t due;
    in_took <= rst_n && in_valid && !in_stall;
    out_took <= rst_n && out_valid && !out_stall;
    if (rst_n && in_valid && !in_stall) take_element(in_value, in_last_item);
    if (rst_n && out_valid && !out_stall) begin
      if (sorted_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %0d final %0b",
                                out_sorted_value, out_final_item));
      end else begin
        due = sorted_due.pop_front();
        if (out_sorted_value !== due.value)
          flag_mismatch($sformatf("sorted_value %0d, expected %0d",
                                  out_sorted_value, due.value));
        if (out_final_item !== due.final_item)
          flag_mismatch($sformatf("final_item %0b, expected %0b on value %0d",
                                  out_final_item, due.final_item, due.value));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("quicksort_engine_tb failed");
      $finish;
    end
  end

  task automatic queue_beat(logic signed [VAL_W-1:0] v, logic last_item);
    load_beat_t b;
    b.value = v;
    b.last_item = last_item;
    load_queue.push_back(b);
  endtask

  task automatic queue_random_set(int count);
    spread_t spread;
    logic signed [VAL_W-1:0] base;
    logic signed [VAL_W-1:0] v;
    int step;
    spread = spread_t'($urandom_range(0, 3));
    base = $urandom;
    step = $urandom_range(0, 1) ? 1 : -1;
    for (int i = 0; i < count; i++) begin
      case (spread)
        SPREAD_WIDE:   v = $urandom;
        SPREAD_NARROW: v = int'($urandom_range(0, 8)) - 4;
        SPREAD_EDGES: begin
          case ($urandom_range(0, 3))
            0:       v = {1'b1, {(VAL_W-1){1'b0}}};
            1:       v = {1'b0, {(VAL_W-1){1'b1}}};
            2:       v = '0;
            default: v = '1;
          endcase
        end
        default:       v = base + i * step;
      endcase
      queue_beat(v, i == count - 1);
    end
  endtask

  task automatic write_order(bit desc);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_descending <= desc;
    do @(posedge clk); while (!cfg_ready);
    order_desc = desc;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Waits until every beat has gone in and every expected result has come out.
  task automatic settle();
    while (load_queue.size() != 0 || in_valid || sorted_due.size() != 0) @(negedge clk);
    repeat (SETTLE_GAP) @(negedge clk);
  endtask

  task automatic queue_mixed_set();
    queue_beat(0, 1'b0);
    queue_beat(-1, 1'b0);
    queue_beat(1, 1'b0);
    queue_beat(32'sh7fffffff, 1'b0);
    queue_beat(32'sh80000000, 1'b0);
    queue_beat(-1, 1'b0);
    queue_beat(32'sh55555555, 1'b0);
    queue_beat(32'shaaaaaaaa, 1'b1);
  endtask

  initial begin
    int loaded;
    int count;
    bit full_done;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed sets: a lone element, two extremes, mixed values with duplicates, all equal.
    write_order(1'b0);
    queue_beat(32'sh80000000, 1'b1);
    settle();
    queue_beat(32'sh7fffffff, 1'b0);
    queue_beat(32'sh80000000, 1'b1);
    queue_mixed_set();
    queue_beat(5, 1'b0);
    queue_beat(5, 1'b0);
    queue_beat(5, 1'b1);
    settle();
    write_order(1'b1);
    queue_mixed_set();
    settle();

    // Random sets of mostly small sizes, and one that overflows the store.
    loaded = 0;
    full_done = 1'b0;
    while (loaded < RANDOM_ITEMS) begin
      if ($urandom_range(0, 1)) write_order($urandom_range(0, 1));
      in_calm = ($urandom_range(0, 3) == 0);
      out_calm = ($urandom_range(0, 3) == 0);
      if (!full_done && loaded > 30) begin
        count = HELD_MAX + $urandom_range(1, 3);
        full_done = 1'b1;
      end else begin
        count = $urandom_range(1, 12);
      end
      loaded += count;
      queue_random_set(count);
      settle();
    end

    if (sorted_due.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", sorted_due.size()));
    if (mismatch_count == 0) begin
      $display("quicksort_engine_tb passed");
    end else begin
      $display("quicksort_engine_tb failed");
    end
    $finish;
  end

endmodule
